// ===== rtl/yowag_pkg.sv =====
// ----------------------------------------------------------------------------
// yowag_pkg
// Shared types and constants for the yuv 4:2:0 overlay write address generator
// ----------------------------------------------------------------------------
package yowag_pkg;

  localparam int unsigned MaxDimDefault = 4096;

  localparam int unsigned CfgDimW  = 13;
  localparam int unsigned CfgPosW  = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned AddrW    = 24;
  // multiplier operand width, set by the frame width register
  localparam int unsigned OpW      = CfgDimW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_OVERLAY_WIDTH  = 3'd2,
    REG_OVERLAY_HEIGHT = 3'd3,
    REG_START_X        = 3'd4,
    REG_START_Y        = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgDimW-1:0] frame_width;
    logic [CfgDimW-1:0] frame_height;
    logic [CfgDimW-1:0] overlay_width;
    logic [CfgDimW-1:0] overlay_height;
    logic [CfgPosW-1:0] start_x;
    logic [CfgPosW-1:0] start_y;
  } cfg_t;

  // one item after position tracking, ready for the address multiply
  typedef struct packed {
    logic               plane;
    logic               write_enable;
    logic [OpW-1:0]     mul_a;
    logic [OpW-1:0]     mul_b;
    logic [OpW-1:0]     add_c;
    logic [SampleW-1:0] first;
    logic [SampleW-1:0] second;
    logic               plane_done;
  } stage_t;

endpackage

// ===== rtl/yowag_in_if.sv =====
// ----------------------------------------------------------------------------
// yowag_in_if
// Overlay sample channel: valid/ready with one luma sample or chroma pair
// ----------------------------------------------------------------------------
interface yowag_in_if;
  import yowag_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [SampleW-1:0] first_sample;
  logic [SampleW-1:0] second_sample;

  modport source (output valid, func, first_sample, second_sample, input ready);
  modport sink   (input valid, func, first_sample, second_sample, output ready);

endinterface

// ===== rtl/yowag_out_if.sv =====
// ----------------------------------------------------------------------------
// yowag_out_if
// Frame write channel: valid/ready with plane, enable, address and samples
// ----------------------------------------------------------------------------
interface yowag_out_if;
  import yowag_pkg::*;

  logic               valid;
  logic               ready;
  logic               plane;
  logic               write_enable;
  logic [AddrW-1:0]   frame_address;
  logic [SampleW-1:0] write_first;
  logic [SampleW-1:0] write_second;
  logic               plane_done;

  modport source (output valid, plane, write_enable, frame_address, write_first,
                  write_second, plane_done, input ready);
  modport sink   (input valid, plane, write_enable, frame_address, write_first,
                  write_second, plane_done, output ready);

endinterface

// ===== rtl/yuv420_overlay_write_address_generator_unit.sv =====
// an accepted sample passes the tracking stage register, then the result register
// throughput: one item per cycle while the frame write channel is ready, single address multiply-add stage
// a stalled result holds in the output register while the tracking stage still fills
// reset: asynchronous active low; raster counters clear, frame and overlay size
// return to 4096, start position to 0, both pipeline stages empty
// ----------------------------------------------------------------------------
// yuv420_overlay_write_address_generator_unit
// Frame write addresses for a planar yuv 4:2:0 overlay placed in a frame
// ----------------------------------------------------------------------------
module yuv420_overlay_write_address_generator_unit #(
  parameter int unsigned MAX_DIMENSION = yowag_pkg::MaxDimDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [yowag_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [yowag_pkg::CfgDimW-1:0]   cfg_data_i,
  yowag_in_if.sink                        item_i,
  yowag_out_if.source                     result_o
);
  import yowag_pkg::*;

  cfg_t   cfg_q;
  logic   stage_valid;
  logic   stage_ready;
  stage_t stage;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= CfgDimW'(4096);
      cfg_q.frame_height   <= CfgDimW'(4096);
      cfg_q.overlay_width  <= CfgDimW'(4096);
      cfg_q.overlay_height <= CfgDimW'(4096);
      cfg_q.start_x        <= '0;
      cfg_q.start_y        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i;
        REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i;
        REG_OVERLAY_WIDTH:  cfg_q.overlay_width  <= cfg_data_i;
        REG_OVERLAY_HEIGHT: cfg_q.overlay_height <= cfg_data_i;
        REG_START_X:        cfg_q.start_x        <= cfg_data_i[CfgPosW-1:0];
        REG_START_Y:        cfg_q.start_y        <= cfg_data_i[CfgPosW-1:0];
        default: begin
        end
      endcase
    end
  end

  yowag_track #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_i        (item_i),
    .stage_ready_i (stage_ready),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  yowag_addr u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .stage_ready_o (stage_ready),
    .result_o      (result_o)
  );

  // a dropped write never carries an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.write_enable |-> result_o.frame_address == '0)
    else $error("dropped write with nonzero address");

  // luma writes carry no second sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.plane |-> result_o.write_second == '0)
    else $error("luma write with nonzero second sample");

  // an accepted item always lands in the tracking stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> stage_valid)
    else $error("accepted item lost before the address stage");

  // a held tracking stage means the output side is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && !stage_ready |-> result_o.valid && !result_o.ready)
    else $error("tracking stage stalled without output backpressure");

endmodule

// ===== rtl/yowag_track.sv =====
// ----------------------------------------------------------------------------
// yowag_track
// Luma and chroma raster counters, frame bound check and address operands
// ----------------------------------------------------------------------------
module yowag_track #(
  parameter int unsigned MAX_DIMENSION = yowag_pkg::MaxDimDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  yowag_pkg::cfg_t   cfg_i,
  yowag_in_if.sink          item_i,
  input  logic              stage_ready_i,
  output logic              stage_valid_o,
  output yowag_pkg::stage_t stage_o
);
  import yowag_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_DIMENSION);     // luma counter width
  localparam int unsigned DW  = CW + 1;                    // clamped dimension width
  localparam int unsigned CCW = CW - 1;                    // chroma counter width
  localparam int unsigned PW  = ((CW > CfgPosW) ? CW : CfgPosW) + 1;

  logic [CW-1:0]  lcol_q, lcol_d, lrow_q, lrow_d;
  logic [CCW-1:0] ccol_q, ccol_d, crow_q, crow_d;
  logic           valid_q;
  stage_t         stage_q, stage_d;

  logic [31:0]    ow32, oh32, ow_cl32, oh_cl32;
  logic [DW-1:0]  ow_cl, oh_cl;
  logic [CW-1:0]  cw, ch;
  logic [PW-1:0]  lx, ly, cx, cy, crow_addr, ccol_addr;
  logic           l_in, c_in, c_empty;
  logic           lcol_end, lrow_end, ccol_end, crow_end;
  logic           fire;

  assign fire         = item_i.valid && item_i.ready;
  assign item_i.ready = !valid_q || stage_ready_i;

  // clamp overlay size to 1..MAX_DIMENSION
  always_comb begin
    ow32    = 32'(cfg_i.overlay_width);
    oh32    = 32'(cfg_i.overlay_height);
    ow_cl32 = (ow32 == 32'd0) ? 32'd1 :
              (ow32 > 32'(MAX_DIMENSION)) ? 32'(MAX_DIMENSION) : ow32;
    oh_cl32 = (oh32 == 32'd0) ? 32'd1 :
              (oh32 > 32'(MAX_DIMENSION)) ? 32'(MAX_DIMENSION) : oh32;
  end

  assign ow_cl   = DW'(ow_cl32);
  assign oh_cl   = DW'(oh_cl32);
  assign cw      = CW'(ow_cl >> 1);
  assign ch      = CW'(oh_cl >> 1);
  assign c_empty = (cw == '0) || (ch == '0);

  // luma position
  assign lx   = PW'(cfg_i.start_x) + PW'(lcol_q);
  assign ly   = PW'(cfg_i.start_y) + PW'(lrow_q);
  assign l_in = (lx < PW'(cfg_i.frame_width)) && (ly < PW'(cfg_i.frame_height));

  // chroma position checked at twice the chroma coordinate
  assign cx   = PW'(cfg_i.start_x) + PW'({ccol_q, 1'b0});
  assign cy   = PW'(cfg_i.start_y) + PW'({crow_q, 1'b0});
  assign c_in = !c_empty && (cx < PW'(cfg_i.frame_width)) &&
                (cy < PW'(cfg_i.frame_height));
  assign crow_addr = PW'(cfg_i.start_y >> 1) + PW'(crow_q);
  assign ccol_addr = PW'(cfg_i.start_x >> 1) + PW'(ccol_q);

  assign lcol_end = (DW'(lcol_q) + DW'(1)) >= ow_cl;
  assign lrow_end = (DW'(lrow_q) + DW'(1)) >= oh_cl;
  assign ccol_end = (CW'(ccol_q) + CW'(1)) >= cw;
  assign crow_end = (CW'(crow_q) + CW'(1)) >= ch;

  always_comb begin
    lcol_d  = lcol_q;
    lrow_d  = lrow_q;
    ccol_d  = ccol_q;
    crow_d  = crow_q;
    stage_d = '0;
    stage_d.plane = item_i.func;
    stage_d.first = item_i.first_sample;
    if (!item_i.func) begin
      stage_d.write_enable = l_in;
      stage_d.plane_done   = lcol_end && lrow_end;
      if (l_in) begin
        stage_d.mul_a = OpW'(ly);
        stage_d.mul_b = cfg_i.frame_width;
        stage_d.add_c = OpW'(lx);
      end
      if (lcol_end) begin
        lcol_d = '0;
        lrow_d = lrow_end ? '0 : lrow_q + CW'(1);
      end else begin
        lcol_d = lcol_q + CW'(1);
      end
    end else begin
      stage_d.second       = item_i.second_sample;
      stage_d.write_enable = c_in;
      if (c_in) begin
        stage_d.mul_a = OpW'(crow_addr);
        stage_d.mul_b = {1'b0, cfg_i.frame_width[CfgDimW-1:1]};
        stage_d.add_c = OpW'(ccol_addr);
      end
      if (c_empty) begin
        // no chroma raster at all
        ccol_d = '0;
        crow_d = '0;
        stage_d.plane_done = 1'b1;
      end else begin
        stage_d.plane_done = ccol_end && crow_end;
        if (ccol_end) begin
          ccol_d = '0;
          crow_d = crow_end ? '0 : crow_q + CCW'(1);
        end else begin
          ccol_d = ccol_q + CCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcol_q  <= '0;
      lrow_q  <= '0;
      ccol_q  <= '0;
      crow_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (fire) begin
        lcol_q <= lcol_d;
        lrow_q <= lrow_d;
        ccol_q <= ccol_d;
        crow_q <= crow_d;
      end
      if (item_i.ready) begin
        valid_q <= item_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      stage_q <= stage_d;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;

endmodule

// ===== rtl/yowag_addr.sv =====
// ----------------------------------------------------------------------------
// yowag_addr
// Address multiply-add and result register toward the frame write channel
// ----------------------------------------------------------------------------
module yowag_addr (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              stage_valid_i,
  input  yowag_pkg::stage_t stage_i,
  output logic              stage_ready_o,
  yowag_out_if.source       result_o
);
  import yowag_pkg::*;

  logic [2*OpW-1:0]   prod;
  logic [AddrW-1:0]   addr_d;
  logic               valid_q;
  logic               plane_q, we_q, done_q;
  logic [AddrW-1:0]   addr_q;
  logic [SampleW-1:0] first_q, second_q;
  logic               load;

  // operands are zero for a dropped write, so the address comes out zero
  assign prod   = stage_i.mul_a * stage_i.mul_b;
  assign addr_d = AddrW'(prod) + AddrW'(stage_i.add_c);

  assign stage_ready_o = !valid_q || result_o.ready;
  assign load          = stage_valid_i && stage_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (stage_ready_o) begin
      valid_q <= stage_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      plane_q  <= stage_i.plane;
      we_q     <= stage_i.write_enable;
      addr_q   <= addr_d;
      first_q  <= stage_i.first;
      second_q <= stage_i.second;
      done_q   <= stage_i.plane_done;
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.plane         = plane_q;
  assign result_o.write_enable  = we_q;
  assign result_o.frame_address = addr_q;
  assign result_o.write_first   = first_q;
  assign result_o.write_second  = second_q;
  assign result_o.plane_done    = done_q;

endmodule
